[rtl/fprf_pkg.sv]
// Shared constants, command/status types and bit-scan helpers for the free page run finder.
package fprf_pkg;

	localparam int DIR_SLOTS_DEF       = 1024;
	localparam int ENTRIES_PER_DIR_DEF = 1024;

	localparam int ACTION_W   = 2;
	localparam int IDX_W      = 10;
	localparam int WANTED_W   = 21;
	localparam int BOUND_W    = 11;
	localparam int PAGE_OUT_W = 20;
	localparam int WORD_W     = 64;
	localparam int BIT_W      = 6;
	localparam int CNT_W      = 7;

	localparam logic [ACTION_W-1:0] ACT_SET_DIR = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SET_ENT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_SEARCH  = 2'd2;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic dir_wr;
		logic dir_rd;
		logic word_rd_wr;
		logic word_wr;
		logic word_rd;
		logic absent_step;
		logic word_step;
		logic out_load;
	} fprf_cmd_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic                dir_ok;
		logic                ent_ok;
		logic                empty;
		logic                present;
		logic                absent_hit;
		logic                word_hit;
		logic                word_last;
		logic                dir_last;
		logic                clr_last;
	} fprf_sts_t;

	function automatic logic [CNT_W-1:0] trail_ones(input logic [WORD_W-1:0] v);
		logic [CNT_W-1:0] n;
		n = CNT_W'(WORD_W);
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!v[i]) begin
				n = CNT_W'(i);
			end
		end
		return n;
	endfunction

	function automatic logic [CNT_W-1:0] lead_ones(input logic [WORD_W-1:0] v);
		logic [CNT_W-1:0] n;
		n = CNT_W'(WORD_W);
		for (int i = 0; i < WORD_W; i++) begin
			if (!v[i]) begin
				n = CNT_W'(WORD_W - 1 - i);
			end
		end
		return n;
	endfunction

	function automatic logic [BIT_W-1:0] low_index(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] n;
		n = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				n = BIT_W'(i);
			end
		end
		return n;
	endfunction

endpackage

[rtl/fprf_ctrl.sv]
// Controller state machine for the free page run finder.
module fprf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  fprf_pkg::fprf_sts_t sts,
	output fprf_pkg::fprf_cmd_t cmd
);
	import fprf_pkg::*;

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_DECODE  = 4'd2;
	localparam logic [3:0] S_WR_MOD  = 4'd3;
	localparam logic [3:0] S_DIR_RD  = 4'd4;
	localparam logic [3:0] S_DIR_CHK = 4'd5;
	localparam logic [3:0] S_WRD     = 4'd6;
	localparam logic [3:0] S_WEV     = 4'd7;
	localparam logic [3:0] S_DONE    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.action)
					ACT_SET_DIR: begin
						cmd.dir_wr = sts.dir_ok;
						state_d    = S_DONE;
					end
					ACT_SET_ENT: begin
						if (sts.dir_ok && sts.ent_ok) begin
							cmd.word_rd_wr = 1'b1;
							state_d        = S_WR_MOD;
						end else begin
							state_d = S_DONE;
						end
					end
					ACT_SEARCH: begin
						if (sts.empty) begin
							state_d = S_DONE;
						end else begin
							cmd.dir_rd = 1'b1;
							state_d    = S_DIR_CHK;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_WR_MOD: begin
				cmd.word_wr = 1'b1;
				state_d     = S_DONE;
			end
			S_DIR_RD: begin
				cmd.dir_rd = 1'b1;
				state_d    = S_DIR_CHK;
			end
			S_DIR_CHK: begin
				if (!sts.present) begin
					cmd.absent_step = 1'b1;
					if (sts.absent_hit || sts.dir_last) begin
						state_d = S_DONE;
					end else begin
						state_d = S_DIR_RD;
					end
				end else begin
					cmd.word_rd = 1'b1;
					state_d     = S_WEV;
				end
			end
			S_WRD: begin
				cmd.word_rd = 1'b1;
				state_d     = S_WEV;
			end
			S_WEV: begin
				cmd.word_step = 1'b1;
				if (sts.word_hit) begin
					state_d = S_DONE;
				end else if (sts.word_last) begin
					state_d = sts.dir_last ? S_DONE : S_DIR_RD;
				end else begin
					state_d = S_WRD;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

[rtl/fprf_dp.sv]
// Datapath of the free page run finder: page map memories, run tracking and result register.
module fprf_dp #(
	parameter int DIR_SLOTS       = fprf_pkg::DIR_SLOTS_DEF,
	parameter int ENTRIES_PER_DIR = fprf_pkg::ENTRIES_PER_DIR_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [fprf_pkg::ACTION_W-1:0]      action,
	input  logic [fprf_pkg::IDX_W-1:0]         dir_index,
	input  logic [fprf_pkg::IDX_W-1:0]         entry_index,
	input  logic                               bit_value,
	input  logic [fprf_pkg::WANTED_W-1:0]      pages_wanted,
	input  logic [fprf_pkg::BOUND_W-1:0]       start_dir,
	input  logic [fprf_pkg::BOUND_W-1:0]       end_dir,
	input  fprf_pkg::fprf_cmd_t                cmd,
	output fprf_pkg::fprf_sts_t                sts,
	output logic                               found,
	output logic [fprf_pkg::PAGE_OUT_W-1:0]    first_page
);
	import fprf_pkg::*;

	localparam int WPD        = (ENTRIES_PER_DIR + WORD_W - 1) / WORD_W;
	localparam int LAST_BITS  = ENTRIES_PER_DIR - WORD_W * (WPD - 1);
	localparam int WORD_COUNT = DIR_SLOTS * WPD;
	localparam int WADDR_W    = $clog2(WORD_COUNT);
	localparam int DIR_AW     = $clog2(DIR_SLOTS);
	localparam int DCNT_W     = $clog2(DIR_SLOTS + 1);
	localparam int KW         = (WPD > 1) ? $clog2(WPD) : 1;
	localparam int PW         = $clog2(DIR_SLOTS * ENTRIES_PER_DIR + 1);
	localparam int RUN_W      = WANTED_W + 1;
	localparam int AMUL_W     = WADDR_W + BOUND_W;
	localparam int PMUL_W     = PW + BOUND_W;
	localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);
	localparam logic [WADDR_W:0]  DIR_LIM   = (WADDR_W + 1)'(DIR_SLOTS);

	logic [WORD_W-1:0] word_mem [WORD_COUNT];
	logic              dir_mem  [DIR_SLOTS];

	logic [ACTION_W-1:0] action_q;
	logic [IDX_W-1:0]    dir_idx_q;
	logic [IDX_W-1:0]    ent_idx_q;
	logic                bit_q;
	logic [WANTED_W-1:0] wanted_q;
	logic                empty_q;
	logic [DCNT_W-1:0]   hi_q;
	logic [WORD_W-1:0]   en_q;
	logic                wle64_q;
	logic [DCNT_W-1:0]   d_q;
	logic [KW-1:0]       k_q;
	logic [WADDR_W-1:0]  waddr_q;
	logic [PW-1:0]       pb_q;
	logic [RUN_W-1:0]    run_q;
	logic [PW-1:0]       begin_q;
	logic                res_found_q;
	logic [PW-1:0]       res_page_q;
	logic                found_q;
	logic [PAGE_OUT_W-1:0] first_page_q;
	logic [WADDR_W-1:0]  clr_q;
	logic [WORD_W-1:0]   rd_word_q;
	logic                rd_dir_q;

	logic [BOUND_W-1:0]  hi_c;
	logic [WADDR_W-1:0]  rmw_addr;
	logic [WADDR_W-1:0]  raddr;
	logic [WORD_W-1:0]   new_word;
	logic                word_last;
	logic [CNT_W-1:0]    n;
	logic [WORD_W-1:0]   vmask;
	logic [WORD_W-1:0]   f;
	logic [WORD_W-1:0]   g;
	logic [CNT_W-1:0]    tz;
	logic [CNT_W-1:0]    tr;
	logic [WORD_W-1:0]   h;
	logic [BIT_W-1:0]    p_idx;
	logic [CNT_W-1:0]    off;
	logic                run_open;
	logic [PW-1:0]       start_page;
	logic [RUN_W-1:0]    sum_w;
	logic [RUN_W-1:0]    sum_d;
	logic                hit_a;
	logic                word_hit;
	logic                absent_hit;
	logic [PW-1:0]       word_page;

	assign hi_c = (end_dir > BOUND_W'(DIR_SLOTS)) ? BOUND_W'(DIR_SLOTS) : end_dir;

	assign rmw_addr = WADDR_W'(AMUL_W'(dir_idx_q) * AMUL_W'(WPD)
		+ AMUL_W'(ent_idx_q[IDX_W-1:BIT_W]));
	assign raddr    = cmd.word_rd_wr ? rmw_addr : waddr_q;

	always_comb begin
		new_word = rd_word_q;
		new_word[ent_idx_q[BIT_W-1:0]] = bit_q;
	end

	assign word_last = (k_q == KW'(WPD - 1));
	assign n         = word_last ? CNT_W'(LAST_BITS) : CNT_W'(WORD_W);
	assign vmask     = word_last ? LAST_MASK : {WORD_W{1'b1}};
	assign f         = ~rd_word_q & vmask;
	assign g         = ~rd_word_q | ~vmask;
	assign tz        = trail_ones(f);
	assign tr        = lead_ones(g) - (CNT_W'(WORD_W) - n);

	// Flag each bit where a free run of the wanted length ends inside the word.
	always_comb begin
		for (int p = 0; p < WORD_W; p++) begin
			h[p] = 1'b1;
			for (int j = 0; j < WORD_W; j++) begin
				if (j <= p) begin
					h[p] = h[p] & (f[p-j] | ~en_q[j]);
				end else begin
					h[p] = h[p] & ~en_q[j];
				end
			end
		end
	end

	assign p_idx      = low_index(h);
	assign off        = CNT_W'(p_idx) + CNT_W'(1) - wanted_q[CNT_W-1:0];
	assign run_open   = (run_q != '0);
	assign start_page = run_open ? begin_q : pb_q;
	assign sum_w      = run_q + RUN_W'(tz);
	assign sum_d      = run_q + RUN_W'(ENTRIES_PER_DIR);
	assign hit_a      = (sum_w >= RUN_W'(wanted_q));
	assign word_hit   = hit_a | (wle64_q & (|h));
	assign absent_hit = (sum_d >= RUN_W'(wanted_q));
	assign word_page  = hit_a ? start_page : pb_q + PW'(off);

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			word_mem[clr_q] <= '0;
		end else if (cmd.word_wr) begin
			word_mem[rmw_addr] <= new_word;
		end
		if (cmd.word_rd || cmd.word_rd_wr) begin
			rd_word_q <= word_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step && ({1'b0, clr_q} < DIR_LIM)) begin
			dir_mem[clr_q[DIR_AW-1:0]] <= 1'b0;
		end else if (cmd.dir_wr) begin
			dir_mem[dir_idx_q[DIR_AW-1:0]] <= bit_q;
		end
		if (cmd.dir_rd) begin
			rd_dir_q <= dir_mem[d_q[DIR_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + WADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q    <= action;
			dir_idx_q   <= dir_index;
			ent_idx_q   <= entry_index;
			bit_q       <= bit_value;
			wanted_q    <= pages_wanted;
			empty_q     <= (pages_wanted == '0) || (start_dir >= hi_c);
			hi_q        <= DCNT_W'(hi_c);
			for (int j = 0; j < WORD_W; j++) begin
				en_q[j] <= (pages_wanted > WANTED_W'(j));
			end
			wle64_q     <= (pages_wanted <= WANTED_W'(WORD_W));
			d_q         <= DCNT_W'(start_dir);
			k_q         <= '0;
			waddr_q     <= WADDR_W'(AMUL_W'(start_dir) * AMUL_W'(WPD));
			pb_q        <= PW'(PMUL_W'(start_dir) * PMUL_W'(ENTRIES_PER_DIR));
			run_q       <= '0;
			res_found_q <= 1'b0;
			res_page_q  <= '0;
		end else if (cmd.absent_step) begin
			run_q   <= sum_d;
			begin_q <= start_page;
			pb_q    <= pb_q + PW'(ENTRIES_PER_DIR);
			waddr_q <= waddr_q + WADDR_W'(WPD);
			d_q     <= d_q + DCNT_W'(1);
			if (absent_hit) begin
				res_found_q <= 1'b1;
				res_page_q  <= start_page;
			end
		end else if (cmd.word_step) begin
			if (tz == n) begin
				run_q   <= run_q + RUN_W'(n);
				begin_q <= start_page;
			end else begin
				run_q   <= RUN_W'(tr);
				begin_q <= pb_q + PW'(n) - PW'(tr);
			end
			pb_q    <= pb_q + PW'(n);
			waddr_q <= waddr_q + WADDR_W'(1);
			k_q     <= word_last ? '0 : k_q + KW'(1);
			if (word_last) begin
				d_q <= d_q + DCNT_W'(1);
			end
			if (word_hit) begin
				res_found_q <= 1'b1;
				res_page_q  <= word_page;
			end
		end
		if (cmd.out_load) begin
			found_q      <= res_found_q;
			first_page_q <= PAGE_OUT_W'(res_page_q);
		end
	end

	assign sts.action     = action_q;
	assign sts.dir_ok     = ({1'b0, dir_idx_q} < (IDX_W + 1)'(DIR_SLOTS));
	assign sts.ent_ok     = ({1'b0, ent_idx_q} < (IDX_W + 1)'(ENTRIES_PER_DIR));
	assign sts.empty      = empty_q;
	assign sts.present    = rd_dir_q;
	assign sts.absent_hit = absent_hit;
	assign sts.word_hit   = word_hit;
	assign sts.word_last  = word_last;
	assign sts.dir_last   = ((d_q + DCNT_W'(1)) == hi_q);
	assign sts.clr_last   = (clr_q == WADDR_W'(WORD_COUNT - 1));

	assign found      = found_q;
	assign first_page = first_page_q;

endmodule

[rtl/free_page_run_finder.sv]
// Directory writes are decoded and written; entry writes read, modify and write back an entry word.
// Search: each absent directory walked counts as a whole free run, and each present directory
// walked is read one 64-bit entry word at a time from the word memory and scanned.
// One transaction in work at a time; the next is taken while the previous result waits.
// Reset: asynchronous; a clearing pass then zeroes one word per cycle, all
// DIR_SLOTS*ceil(ENTRIES_PER_DIR/64) words (16384 at default size), with in_stall held high.
module free_page_run_finder #(
	parameter int DIR_SLOTS       = fprf_pkg::DIR_SLOTS_DEF,
	parameter int ENTRIES_PER_DIR = fprf_pkg::ENTRIES_PER_DIR_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [fprf_pkg::ACTION_W-1:0]   action,
	input  logic [fprf_pkg::IDX_W-1:0]      dir_index,
	input  logic [fprf_pkg::IDX_W-1:0]      entry_index,
	input  logic                            bit_value,
	input  logic [fprf_pkg::WANTED_W-1:0]   pages_wanted,
	input  logic [fprf_pkg::BOUND_W-1:0]    start_dir,
	input  logic [fprf_pkg::BOUND_W-1:0]    end_dir,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            found,
	output logic [fprf_pkg::PAGE_OUT_W-1:0] first_page
);
	import fprf_pkg::*;

	fprf_cmd_t cmd;
	fprf_sts_t sts;

	fprf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	fprf_dp #(
		.DIR_SLOTS       (DIR_SLOTS),
		.ENTRIES_PER_DIR (ENTRIES_PER_DIR)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.action       (action),
		.dir_index    (dir_index),
		.entry_index  (entry_index),
		.bit_value    (bit_value),
		.pages_wanted (pages_wanted),
		.start_dir    (start_dir),
		.end_dir      (end_dir),
		.cmd          (cmd),
		.sts          (sts),
		.found        (found),
		.first_page   (first_page)
	);

	ap_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> cmd.load)
		else $error("accepted transaction not loaded");

	ap_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.clr_step, cmd.dir_wr, cmd.word_wr,
			cmd.absent_step, cmd.word_step, cmd.out_load}))
		else $error("conflicting datapath commands");

	ap_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> in_stall)
		else $error("input open during clearing pass");

	ap_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("loaded result not presented");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for free_page_run_finder: page map writes and first-fit run searches.
module tb;
	import fprf_pkg::*;

	localparam int DIRS = DIR_SLOTS_DEF;
	localparam int ENTRIES = ENTRIES_PER_DIR_DEF;
	localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
	localparam int RANDOM_ITEMS = 450;
	localparam int QUIET_LIMIT = 200000;
	localparam int TAIL_CYCLES = 64;

	typedef struct {
		logic [ACTION_W-1:0] action;
		logic [IDX_W-1:0]    dir_index;
		logic [IDX_W-1:0]    entry_index;
		logic                bit_value;
		logic [WANTED_W-1:0] pages_wanted;
		logic [BOUND_W-1:0]  start_dir;
		logic [BOUND_W-1:0]  end_dir;
	} page_request_t;

	typedef struct {
		logic                  found;
		logic [PAGE_OUT_W-1:0] first_page;
	} run_answer_t;

	class page_run_board;
		bit dir_map [DIRS];
		bit [ENTRIES-1:0] used_map [DIRS];
		run_answer_t awaited [$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function run_answer_t first_fit(page_request_t r);
			run_answer_t a;
			int unsigned hi;
			int unsigned run;
			int unsigned head;
			bit in_run;
			a.found = 1'b0;
			a.first_page = '0;
			run = 0;
			head = 0;
			in_run = 1'b0;
			if (r.pages_wanted == 0) begin
				return a;
			end
			hi = r.end_dir;
			if (hi > DIRS) begin
				hi = DIRS;
			end
			for (int unsigned d = r.start_dir; d < hi; d++) begin
				if (!dir_map[d]) begin
					if (!in_run) begin
						in_run = 1'b1;
						head = d * ENTRIES;
					end
					run += ENTRIES;
					if (run >= r.pages_wanted) begin
						a.found = 1'b1;
						a.first_page = PAGE_OUT_W'(head);
						return a;
					end
				end else begin
					for (int unsigned e = 0; e < ENTRIES; e++) begin
						if (used_map[d][e]) begin
							in_run = 1'b0;
							run = 0;
						end else begin
							if (!in_run) begin
								in_run = 1'b1;
								head = d * ENTRIES + e;
							end
							run++;
							if (run >= r.pages_wanted) begin
								a.found = 1'b1;
								a.first_page = PAGE_OUT_W'(head);
								return a;
							end
						end
					end
				end
			end
			return a;
		endfunction

		function void note_request(page_request_t r);
			run_answer_t a;
			a.found = 1'b0;
			a.first_page = '0;
			case (r.action)
				ACT_SET_DIR: dir_map[r.dir_index] = r.bit_value;
				ACT_SET_ENT: used_map[r.dir_index][r.entry_index] = r.bit_value;
				ACT_SEARCH: a = first_fit(r);
				default: ;
			endcase
			awaited.push_back(a);
		endfunction

		function void check_answer(logic got_found, logic [PAGE_OUT_W-1:0] got_page);
			run_answer_t a;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR: unexpected result found=%0b first_page=%0d", got_found,
						got_page);
				end
				return;
			end
			a = awaited.pop_front();
			if (got_found !== a.found || got_page !== a.first_page) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR: found exp %0b got %0b, first_page exp %0d got %0d",
						a.found, got_found, a.first_page, got_page);
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [ACTION_W-1:0]   action;
	logic [IDX_W-1:0]      dir_index;
	logic [IDX_W-1:0]      entry_index;
	logic                  bit_value;
	logic [WANTED_W-1:0]   pages_wanted;
	logic [BOUND_W-1:0]    start_dir;
	logic [BOUND_W-1:0]    end_dir;
	logic                  out_valid;
	logic                  out_stall;
	logic                  found;
	logic [PAGE_OUT_W-1:0] first_page;

	page_run_board board = new();
	bit steady = 1'b0;
	int quiet_cycles = 0;

	free_page_run_finder DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.dir_index   (dir_index),
		.entry_index (entry_index),
		.bit_value   (bit_value),
		.pages_wanted(pages_wanted),
		.start_dir   (start_dir),
		.end_dir     (end_dir),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.first_page  (first_page)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic page_request_t make_req(logic [ACTION_W-1:0] act, int dir, int ent,
			bit val, int wanted, int lo, int hi);
		page_request_t r;
		r.action = act;
		r.dir_index = IDX_W'(dir);
		r.entry_index = IDX_W'(ent);
		r.bit_value = val;
		r.pages_wanted = WANTED_W'(wanted);
		r.start_dir = BOUND_W'(lo);
		r.end_dir = BOUND_W'(hi);
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] active_dir();
		if ($urandom_range(0, 3) == 0) begin
			return IDX_W'($urandom_range(1020, 1023));
		end
		return IDX_W'($urandom_range(0, 15));
	endfunction

	function automatic page_request_t random_request();
		page_request_t r;
		int pick;
		int shape;
		r.action = ACTION_W'($urandom);
		r.dir_index = IDX_W'($urandom);
		r.entry_index = IDX_W'($urandom);
		r.bit_value = 1'($urandom);
		r.pages_wanted = WANTED_W'($urandom);
		r.start_dir = BOUND_W'($urandom);
		r.end_dir = BOUND_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			r.action = ACT_SET_ENT;
			if ($urandom_range(0, 19) != 0) begin
				r.dir_index = active_dir();
			end
			if ($urandom_range(0, 1) == 0) begin
				r.entry_index = IDX_W'($urandom_range(0, 127));
			end
			r.bit_value = ($urandom_range(0, 9) < 7);
		end else if (pick < 45) begin
			r.action = ACT_SET_DIR;
			r.dir_index = active_dir();
			r.bit_value = ($urandom_range(0, 9) < 7);
		end else if (pick < 47) begin
			r.action = ACT_SET_DIR;
		end else if (pick < 50) begin
			r.action = ACT_NONE;
		end else begin
			r.action = ACT_SEARCH;
			shape = $urandom_range(0, 99);
			if (shape < 80) begin
				r.start_dir = BOUND_W'($urandom_range(0, 17));
			end else if (shape < 92) begin
				r.start_dir = BOUND_W'($urandom_range(1016, 1023));
			end
			if (shape < 92) begin
				r.end_dir = r.start_dir + BOUND_W'($urandom_range(0, 10));
			end
			shape = $urandom_range(0, 99);
			if (shape < 35) begin
				r.pages_wanted = WANTED_W'($urandom_range(1, 64));
			end else if (shape < 65) begin
				r.pages_wanted = WANTED_W'($urandom_range(1, 2048));
			end else if (shape < 85) begin
				r.pages_wanted = WANTED_W'($urandom_range(1, 10000));
			end else if (shape < 92) begin
				r.pages_wanted = '0;
			end
		end
		return r;
	endfunction

	task automatic send_request(page_request_t r);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= r.action;
		dir_index <= r.dir_index;
		entry_index <= r.entry_index;
		bit_value <= r.bit_value;
		pages_wanted <= r.pages_wanted;
		start_dir <= r.start_dir;
		end_dir <= r.end_dir;
		do @(posedge clk); while (in_stall !== 1'b0);
		board.note_request(r);
	endtask

	// hold off new transactions until every pending answer is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.awaited.size() != 0) @(posedge clk);
	endtask

	task automatic run_directed();
		send_request(make_req(ACT_SEARCH, 0, 0, 0, 1, 0, 1));
		send_request(make_req(ACT_SEARCH, 0, 0, 0, 0, 0, 1024));
		send_request(make_req(ACT_SEARCH, 0, 0, 0, 1, 5, 5));
		send_request(make_req(ACT_SEARCH, 0, 0, 0, 1, 2047, 2047));
		send_request(make_req(ACT_SEARCH, 0, 0, 0, 1, 900, 3));
		send_request(make_req(ACT_SEARCH, 0, 0, 0, 1048576, 0, 2047));
		send_request(make_req(ACT_SEARCH, 0, 0, 0, 2097151, 0, 2047));
		send_request(make_req(ACT_SEARCH, 0, 0, 0, 1024, 1023, 2047));
		send_request(make_req(ACT_NONE, 1023, 1023, 1, 2097151, 2047, 2047));
		send_request(make_req(ACT_SET_DIR, 0, 0, 1, 0, 0, 0));
		send_request(make_req(ACT_SET_ENT, 0, 0, 1, 0, 0, 0));
		send_request(make_req(ACT_SEARCH, 0, 0, 0, 1, 0, 1));
		send_request(make_req(ACT_SET_ENT, 0, 1023, 1, 0, 0, 0));
		send_request(make_req(ACT_SEARCH, 0, 0, 0, 1022, 0, 1));
		send_request(make_req(ACT_SEARCH, 0, 0, 0, 1023, 0, 1));
		send_request(make_req(ACT_SEARCH, 0, 0, 0, 1024, 0, 2));
		send_request(make_req(ACT_SET_DIR, 1023, 0, 1, 0, 0, 0));
		send_request(make_req(ACT_SET_ENT, 1023, 1023, 1, 0, 0, 0));
		send_request(make_req(ACT_SET_ENT, 1023, 0, 1, 0, 0, 0));
		send_request(make_req(ACT_SEARCH, 0, 0, 0, 1022, 1023, 1024));
		send_request(make_req(ACT_SET_ENT, 0, 0, 0, 0, 0, 0));
		send_request(make_req(ACT_SEARCH, 0, 0, 0, 1023, 0, 1));
		send_request(make_req(ACT_SET_DIR, 0, 0, 0, 0, 0, 0));
		send_request(make_req(ACT_SEARCH, 0, 0, 0, 2048, 0, 2));
		send_request(make_req(ACT_SET_DIR, 1023, 0, 0, 0, 0, 0));
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= ACT_NONE;
		dir_index <= '0;
		entry_index <= '0;
		bit_value <= 1'b0;
		pages_wanted <= '0;
		start_dir <= '0;
		end_dir <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		drain();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0) begin
				steady = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 59) == 0) begin
				drain();
			end
			send_request(random_request());
		end
		in_valid <= 1'b0;
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.awaited.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		int hold;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = steady ? 0 : $urandom_range(0, 10);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			board.check_answer(found, first_page);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
